// ===== hw/rtl/sadc_pkg.sv =====
// ----------------------------------------------------------------------------
// sadc_pkg
// Shared types, byte constants and the CRC-8 step for the datagram builder.
// ----------------------------------------------------------------------------
package sadc_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic       CMD_READ   = 1'b0;
    localparam logic       CMD_WRITE  = 1'b1;

    // byte positions within a datagram
    localparam logic [2:0] POS_SYNC   = 3'd0;
    localparam logic [2:0] POS_NODE   = 3'd1;
    localparam logic [2:0] POS_ADDR   = 3'd2;
    localparam logic [2:0] POS_DATA3  = 3'd3;
    localparam logic [2:0] POS_DATA2  = 3'd4;
    localparam logic [2:0] POS_DATA1  = 3'd5;
    localparam logic [2:0] POS_DATA0  = 3'd6;
    localparam logic [2:0] POS_RD_CRC = 3'd3;
    localparam logic [2:0] POS_WR_CRC = 3'd7;

    // classified request as held in the queue
    typedef struct packed {
        logic        is_write;
        logic [7:0]  node_byte;
        logic [7:0]  addr_byte;
        logic [31:0] data;
    } sadc_req_t;

    // CRC-8, poly 0x07, byte fed LSB first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                            input logic [7:0] byte_in);
        logic [7:0] crc;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[7] ^ byte_in[i]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/sadc_front.sv =====
// ----------------------------------------------------------------------------
// sadc_front
// Accepts access requests and classifies them into queue descriptors.
// ----------------------------------------------------------------------------
module sadc_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [6:0]           s_reg_address,
    input  logic [31:0]          s_write_value,
    input  logic [7:0]           node_address,
    input  logic                 q_full,
    output logic                 q_push,
    output sadc_pkg::sadc_req_t  q_req
);
    import sadc_pkg::*;

    logic is_write;

    assign is_write = (s_cmd == CMD_WRITE);
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

    always_comb begin
        q_req.is_write  = is_write;
        q_req.node_byte = node_address;
        q_req.addr_byte = {1'b0, s_reg_address} | (is_write ? WRITE_FLAG : 8'h00);
        q_req.data      = s_write_value;
    end

endmodule

// ===== hw/rtl/sadc_queue.sv =====
// ----------------------------------------------------------------------------
// sadc_queue
// Two-entry descriptor queue between the request front and the serializer.
// ----------------------------------------------------------------------------
module sadc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sadc_pkg::sadc_req_t  push_req,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output sadc_pkg::sadc_req_t  head_req
);
    import sadc_pkg::*;

    sadc_req_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_req   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== hw/rtl/sadc_back.sv =====
// ----------------------------------------------------------------------------
// sadc_back
// Serializes the head descriptor into datagram bytes, one per cycle unless the
// output is stalled, with a running CRC-8 and a registered output stage.
// ----------------------------------------------------------------------------
module sadc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  sadc_pkg::sadc_req_t  head_req,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_tx_byte,
    output logic                 m_is_last
);
    import sadc_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_tx_byte_reg;
    logic       m_is_last_reg;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       advance;

    assign advance = head_valid && (!m_valid_reg || m_ready);
    assign pop     = advance && cur_last;

    always_comb begin
        cur_last = head_req.is_write ? (pos_reg == POS_WR_CRC) : (pos_reg == POS_RD_CRC);
        case (pos_reg)
            POS_SYNC:  cur_byte = SYNC_BYTE;
            POS_NODE:  cur_byte = head_req.node_byte;
            POS_ADDR:  cur_byte = head_req.addr_byte;
            // a read ends right after the address: position 3 is its CRC
            POS_DATA3: cur_byte = head_req.is_write ? head_req.data[31:24] : crc_reg;
            POS_DATA2: cur_byte = head_req.data[23:16];
            POS_DATA1: cur_byte = head_req.data[15:8];
            POS_DATA0: cur_byte = head_req.data[7:0];
            default:   cur_byte = crc_reg;
        endcase
    end

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            if (cur_last) begin
                pos_next = POS_SYNC;
                crc_next = 8'h00;
            end else begin
                pos_next = pos_reg + 3'd1;
                crc_next = crc_feed(crc_reg, cur_byte);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_SYNC;
            crc_reg     <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tx_byte_reg <= cur_byte;
            m_is_last_reg <= cur_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_is_last = m_is_last_reg;

endmodule

// ===== hw/rtl/serial_access_datagram_crc8_top.sv =====
// ----------------------------------------------------------------------------
// serial_access_datagram_crc8_top
// Builds serial register-access datagrams with a trailing CRC-8.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one register access per transaction (s_cmd 1 = write,
//   s_reg_address, s_write_value). m_* channel: datagram bytes in line
//   order, m_is_last set on the CRC byte. A read gives 4 bytes
//   (sync, node, address, CRC); a write gives 8 (four data bytes, MSB first).
//   cfg_we/cfg_wdata load the node address; write it only while idle.
// First byte: a request accepted into an empty block passes the queue registers
//   and then the output register before m_valid rises.
// Throughput: one byte per cycle on m_* while m_ready is high; the byte
//   serializer with its running CRC is the limit. A two-entry queue lets the
//   next requests be accepted while a datagram is going out.
// Reset (aresetn low, synchronous): queue emptied, output invalid, node
//   address cleared to 0.
// Stall: with m_ready low the output byte holds; the serializer and then the
//   queue fill, after which s_ready drops.
// ----------------------------------------------------------------------------
module serial_access_datagram_crc8_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [6:0]  s_reg_address,
    input  logic [31:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_is_last
);
    import sadc_pkg::*;

    logic [7:0] node_address_reg;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_head_valid;
    sadc_req_t  q_push_req;
    sadc_req_t  q_head_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg <= 8'h00;
        end else if (cfg_we) begin
            node_address_reg <= cfg_wdata;
        end
    end

    sadc_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_reg_address (s_reg_address),
        .s_write_value (s_write_value),
        .node_address  (node_address_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_req         (q_push_req)
    );

    sadc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_req   (q_push_req),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_req   (q_head_req)
    );

    sadc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_req   (q_head_req),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_is_last  (m_is_last)
    );

endmodule

// ===== hw/rtl/sadc_checker.sv =====
// ----------------------------------------------------------------------------
// sadc_checker
// Port-level checks for the datagram builder, bound to the top level.
// ----------------------------------------------------------------------------
module sadc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_tx_byte,
    input logic        m_is_last
);
    import sadc_pkg::*;

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_is_last))
        else $error("output byte changed while stalled");

    // the byte after a datagram's last byte opens a new datagram
    a_sync_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_last) ##1 m_valid |-> m_tx_byte == SYNC_BYTE)
        else $error("datagram does not start with sync byte");

    // reset leaves no output pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // a request was taken before any byte can appear after reset
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn ##1 (aresetn && !(s_valid && s_ready)) |=> !m_valid)
        else $error("output byte without request");

endmodule

bind serial_access_datagram_crc8_top sadc_checker u_sadc_checker (.*);

// ===== tb/sv/sadc_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadc_scoreboard
// Watches the request and byte channels of the datagram builder, works out
// the datagram bytes each accepted request must produce and checks every
// byte leaving the block against them in order.
// ----------------------------------------------------------------------------
module sadc_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [6:0]  s_reg_address,
    input  logic [31:0] s_write_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_is_last,
    output int          fail_count,
    output int          outstanding
);
    import sadc_pkg::*;

    typedef struct {
        logic [7:0] tx_byte;
        logic       is_last;
    } dgram_byte_t;

    dgram_byte_t dgram_q[$];
    dgram_byte_t head;
    logic [7:0]  node_addr;

    // CRC-8 poly 0x07, zero start, each byte shifted in LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                             input logic [7:0] data);
        logic feedback;
        for (int b = 0; b < 8; b++) begin
            feedback = crc[7] ^ data[b];
            crc = crc << 1;
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    task automatic queue_datagram(input logic cmd, input logic [6:0] ra,
                                  input logic [31:0] wv);
        logic [7:0] frame[8];
        int         len;
        logic [7:0] crc;
        dgram_byte_t entry;
        frame[0] = SYNC_BYTE;
        frame[1] = node_addr;
        frame[2] = {1'b0, ra} | ((cmd == CMD_WRITE) ? WRITE_FLAG : 8'h00);
        len = 3;
        if (cmd == CMD_WRITE) begin
            for (int k = 0; k < 4; k++) begin
                frame[3 + k] = wv[31 - 8 * k -: 8];
            end
            len = 7;
        end
        crc = 8'h00;
        for (int k = 0; k < len; k++) begin
            crc = crc8_step(crc, frame[k]);
        end
        frame[len] = crc;
        for (int k = 0; k <= len; k++) begin
            entry.tx_byte = frame[k];
            entry.is_last = (k == len);
            dgram_q.push_back(entry);
        end
    endtask

    initial begin
        fail_count  = 0;
        outstanding = 0;
        node_addr   = 8'h00;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            node_addr = 8'h00;
            dgram_q.delete();
        end else begin
            if (cfg_we) begin
                node_addr = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                queue_datagram(s_cmd, s_reg_address, s_write_value);
            end
            if (m_valid && m_ready) begin
                if (dgram_q.size() == 0) begin
                    $error("unexpected byte transaction: tx_byte %02h is_last %0b",
                           m_tx_byte, m_is_last);
                    fail_count++;
                end else begin
                    head = dgram_q.pop_front();
                    if (m_tx_byte !== head.tx_byte) begin
                        $error("tx_byte mismatch: expected %02h, actual %02h",
                               head.tx_byte, m_tx_byte);
                        fail_count++;
                    end
                    if (m_is_last !== head.is_last) begin
                        $error("is_last mismatch: expected %0b, actual %0b",
                               head.is_last, m_is_last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= dgram_q.size();
    end

endmodule

// ===== tb/sv/tb_serial_access_datagram_crc8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_access_datagram_crc8_top
// Drives register access requests into the datagram builder under several
// node addresses, with random idling on both channels and one long output
// stall, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_serial_access_datagram_crc8_top;
    import sadc_pkg::*;

    localparam int NUM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_LIMIT   = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [6:0]  s_reg_address;
    logic [31:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_tx_byte;
    logic        m_is_last;

    int          fail_count;
    int          outstanding;
    bit          quiet;
    bit          sender_gaps;
    bit          hold_req;
    logic [7:0]  node_setting[NUM_PHASES];

    serial_access_datagram_crc8_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_reg_address (s_reg_address),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_is_last     (m_is_last)
    );

    sadc_scoreboard scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_reg_address (s_reg_address),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_is_last     (m_is_last),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // one request transaction, optionally preceded by an idle burst
    task automatic send_access(input logic cmd, input logic [6:0] ra,
                               input logic [31:0] wv);
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_reg_address <= ra;
        s_write_value <= wv;
        do @(posedge aclk); while (!s_ready);
    endtask

    // only called with s_valid low and every byte delivered
    task automatic set_node(input logic [7:0] value);
        while (outstanding != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, one long hold on request
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        s_valid       = 1'b0;
        s_cmd         = CMD_READ;
        s_reg_address = 7'd0;
        s_write_value = 32'd0;
        quiet         = 1'b0;
        sender_gaps   = 1'b1;
        hold_req      = 1'b0;
        node_setting  = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h00};
        node_setting[2] = 8'($urandom_range(0, 255));
        node_setting[5] = 8'($urandom_range(0, 255));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, node address still at its reset value
        send_access(CMD_READ,  7'd0,   32'h0000_0000);
        send_access(CMD_WRITE, 7'd127, 32'hFFFF_FFFF);
        send_access(CMD_READ,  7'd127, 32'hFFFF_FFFF);   // data ignored on a read
        send_access(CMD_WRITE, 7'd0,   32'h0000_0000);
        send_access(CMD_WRITE, 7'h55,  32'h8000_0000);
        send_access(CMD_WRITE, 7'h2A,  32'h0000_0001);
        send_access(CMD_WRITE, 7'h10,  32'h1234_5678);
        send_access(CMD_READ,  7'h01,  32'hA5A5_A5A5);
        s_valid <= 1'b0;
        @(posedge aclk);

        set_node(8'hFF);
        send_access(CMD_READ,  7'd0,   32'h0000_0000);
        send_access(CMD_WRITE, 7'd127, 32'hFFFF_FFFF);
        send_access(CMD_WRITE, 7'd0,   32'h0000_0000);
        send_access(CMD_READ,  7'h7F,  32'h5555_AAAA);
        s_valid <= 1'b0;
        @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_node(node_setting[p]);
            if (p == 2) begin
                // keep offering while the output is held off
                sender_gaps = 1'b0;
                hold_req    = 1'b1;
            end else begin
                sender_gaps = 1'b1;
            end
            if (p == NUM_PHASES - 1) begin
                quiet = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_access(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                            pick_value());
            end
            s_valid <= 1'b0;
            @(posedge aclk);
        end

        for (int w = 0; w < DRAIN_LIMIT && outstanding != 0; w++) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (outstanding != 0) begin
            $error("datagram bytes never delivered: %0d", outstanding);
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
